### sv/bisc_pkg.sv
package bisc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int SRC_BITS  = 9;
    localparam int DST_BITS  = 13;
    localparam int POS_BITS  = 12;
    localparam int CFG_BITS  = 13;
    localparam int IDX_BITS  = 2;
    localparam int ADDR_W    = 16;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DST_MAX    = 4096;
    localparam int COORD_W   = 8;
    localparam int NUM_W     = 22 + FRAC_BITS;
    localparam int DEN_W     = DST_BITS + 1;
    localparam int QUOT_W    = SRC_BITS + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int TOP_W     = 8 + FRAC_BITS;
    localparam int MIX_W     = TOP_W + FRAC_BITS + 1;

    localparam logic [IDX_BITS-1:0] CFG_SRC_W = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_SRC_H = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_DST_W = 2'd2;
    localparam logic [IDX_BITS-1:0] CFG_DST_H = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_ADDR, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
        ST_CAP, ST_MIX1, ST_MIX2, ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       addr_en;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       shift;
        logic       mix1;
        logic       mix2;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_full;
    } t_sts;

endpackage

### sv/bisc_div.sv
module bisc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bisc_pkg::NUM_W-1:0]  i_num,
    input  logic [bisc_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [bisc_pkg::QUOT_W-1:0] o_quot
);
    import bisc_pkg::*;

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [DEN_W:0]    trial;
    logic              qbit;

    // one quotient bit per cycle
    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign qbit   = (trial >= {1'b0, r_den});
    assign o_done = r_busy && (r_cnt == CNT_W'(NUM_W - 1));
    assign o_quot = r_quot;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (o_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= qbit ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_quot <= {r_quot[QUOT_W-2:0], qbit};
        end
    end

endmodule

### sv/bisc_ctrl.sv
module bisc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    input  bisc_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output bisc_pkg::t_cmd o_cmd
);
    import bisc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_kind) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_DIV;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.addr_en = 1'b1;
                n_state       = ST_RD0;
            end
            ST_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 2'd0;
                n_state      = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 2'd1;
                o_cmd.shift  = 1'b1;
                n_state      = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 2'd2;
                o_cmd.shift  = 1'b1;
                n_state      = ST_RD3;
            end
            ST_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 2'd3;
                o_cmd.shift  = 1'b1;
                n_state      = ST_CAP;
            end
            ST_CAP: begin
                o_cmd.shift = 1'b1;
                n_state     = ST_MIX1;
            end
            ST_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/bisc_dp.sv
module bisc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bisc_pkg::t_cmd                i_cmd,
    output bisc_pkg::t_sts                o_sts,
    input  logic [31:0]                   i_pixel_in,
    input  logic                          i_cfg_we,
    input  logic [bisc_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [bisc_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_pixel_out,
    output logic                          o_last,
    output logic                          o_all_opaque
);
    import bisc_pkg::*;

    logic [SRC_BITS-1:0] r_src_w, r_src_h;
    logic [DST_BITS-1:0] r_dst_w, r_dst_h;
    logic [ADDR_W-1:0]   r_load_idx;
    logic [POS_BITS-1:0] r_col, r_row;
    logic                r_opq;

    logic [31:0]         mem [MEM_DEPTH];
    logic [31:0]         r_rdata;
    logic [ADDR_W-1:0]   mem_addr;
    logic [ADDR_W-1:0]   r_addr [4];
    logic [31:0]         r_pix [4];
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [TOP_W-1:0]    r_top [4];
    logic [TOP_W-1:0]    r_bot [4];
    logic [31:0]         r_res;

    logic                r_out_valid;
    logic [31:0]         r_out_pix;
    logic                r_out_last, r_out_opq;

    logic [21:0]         num_x, num_y;
    logic                done_x, done_y;
    logic [QUOT_W-1:0]   quot_x, quot_y;
    logic [SRC_BITS-1:0] gx, gy;
    logic [COORD_W-1:0]  x0, x1, y0, y1;
    logic [SRC_BITS-1:0] src_w_m1, src_h_m1;
    logic                is_last, col_end, opq_now;
    logic [SRC_BITS-1:0] sat_src;
    logic [DST_BITS-1:0] sat_dst;

    // numerators offset by one denominator so they stay non-negative
    assign num_x = 22'({r_col, 1'b1} * r_src_w) + 22'(r_dst_w);
    assign num_y = 22'({r_row, 1'b1} * r_src_h) + 22'(r_dst_h);

    bisc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   ({num_x, {FRAC_BITS{1'b0}}}),
        .i_den   ({r_dst_w, 1'b0}),
        .o_done  (done_x),
        .o_quot  (quot_x)
    );

    bisc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   ({num_y, {FRAC_BITS{1'b0}}}),
        .i_den   ({r_dst_h, 1'b0}),
        .o_done  (done_y),
        .o_quot  (quot_y)
    );

    assign o_sts.div_done = done_x && done_y;
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    // quotient integer part is floor + 1
    assign gx       = quot_x[QUOT_W-1:FRAC_BITS];
    assign gy       = quot_y[QUOT_W-1:FRAC_BITS];
    assign src_w_m1 = r_src_w - 1'b1;
    assign src_h_m1 = r_src_h - 1'b1;
    assign x0 = (gx == '0) ? '0 : COORD_W'(gx - 1'b1);
    assign x1 = (gx > src_w_m1) ? COORD_W'(src_w_m1) : COORD_W'(gx);
    assign y0 = (gy == '0) ? '0 : COORD_W'(gy - 1'b1);
    assign y1 = (gy > src_h_m1) ? COORD_W'(src_h_m1) : COORD_W'(gy);

    always_comb begin
        sat_src = i_cfg_data[SRC_BITS-1:0];
        if (sat_src == '0) begin
            sat_src = SRC_BITS'(1);
        end
        sat_dst = i_cfg_data[DST_BITS-1:0];
        if (sat_dst == '0) begin
            sat_dst = DST_BITS'(1);
        end else if (sat_dst > DST_BITS'(DST_MAX)) begin
            sat_dst = DST_BITS'(DST_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_BITS'(1);
            r_src_h <= SRC_BITS'(1);
            r_dst_w <= DST_BITS'(1);
            r_dst_h <= DST_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_W: r_src_w <= (sat_src > SRC_BITS'(MAX_WIDTH)) ?
                                      SRC_BITS'(MAX_WIDTH) : sat_src;
                CFG_SRC_H: r_src_h <= (sat_src > SRC_BITS'(MAX_HEIGHT)) ?
                                      SRC_BITS'(MAX_HEIGHT) : sat_src;
                CFG_DST_W: r_dst_w <= sat_dst;
                CFG_DST_H: r_dst_h <= sat_dst;
                default: begin
                end
            endcase
        end
    end

    // frame store, one port
    assign mem_addr = i_cmd.load ? r_load_idx : r_addr[i_cmd.rd_sel];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[mem_addr] <= i_pixel_in;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_en) begin
            r_addr[0] <= ADDR_W'(y0 * r_src_w + x0);
            r_addr[1] <= ADDR_W'(y0 * r_src_w + x1);
            r_addr[2] <= ADDR_W'(y1 * r_src_w + x0);
            r_addr[3] <= ADDR_W'(y1 * r_src_w + x1);
            r_fx      <= quot_x[FRAC_BITS-1:0];
            r_fy      <= quot_y[FRAC_BITS-1:0];
        end
        if (i_cmd.shift) begin
            r_pix[0] <= r_rdata;
            r_pix[1] <= r_pix[0];
            r_pix[2] <= r_pix[1];
            r_pix[3] <= r_pix[2];
        end
    end

    // r_pix[3] p00, r_pix[2] p01, r_pix[1] p10, r_pix[0] p11
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (i_cmd.mix1) begin
                r_top[c] <= TOP_W'(r_pix[3][8*c +: 8] * ((FRAC_BITS+1)'(1 << FRAC_BITS) - r_fx)
                                 + r_pix[2][8*c +: 8] * r_fx);
                r_bot[c] <= TOP_W'(r_pix[1][8*c +: 8] * ((FRAC_BITS+1)'(1 << FRAC_BITS) - r_fx)
                                 + r_pix[0][8*c +: 8] * r_fx);
            end
            if (i_cmd.mix2) begin
                r_res[8*c +: 8] <= 8'((MIX_W'(r_top[c]) * ((FRAC_BITS+1)'(1 << FRAC_BITS) - r_fy)
                                     + MIX_W'(r_bot[c]) * r_fy) >> (2*FRAC_BITS));
            end
        end
    end

    assign col_end = ({1'b0, r_col} + 1'b1) >= r_dst_w;
    assign is_last = col_end && (({1'b0, r_row} + 1'b1) >= r_dst_h);
    assign opq_now = r_opq && (r_res[31:24] == 8'hFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_opq       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_SRC_W || i_cfg_idx == CFG_SRC_H ||
                             i_cfg_idx == CFG_DST_W || i_cfg_idx == CFG_DST_H)) begin
                r_load_idx <= '0;
                r_col      <= '0;
                r_row      <= '0;
                r_opq      <= 1'b1;
            end else if (i_cmd.load) begin
                r_load_idx <= r_load_idx + 1'b1;
            end else if (i_cmd.emit) begin
                if (is_last) begin
                    r_col <= '0;
                    r_row <= '0;
                    r_opq <= 1'b1;
                end else if (col_end) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                    r_opq <= opq_now;
                end else begin
                    r_col <= r_col + 1'b1;
                    r_opq <= opq_now;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pix  <= r_res;
            r_out_last <= is_last;
            r_out_opq  <= opq_now;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_last       = r_out_last;
    assign o_all_opaque = r_out_opq;

endmodule

### sv/bilinear_image_scaler_unit.sv
// load items are taken one per cycle while the unit is idle
// compute items pass through 30 steps of the serial coordinate divider, an address
// cycle, four reads of the single-port frame store, a capture cycle, two mix stages
// and the output cycle, which stalls on a full output
// one compute item is in flight at a time; the output register frees the input side
// reset (synchronous, active low) sets all sizes to 1, position and load index to 0
module bilinear_image_scaler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [31:0]                   i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_pixel_out,
    output logic                          o_last,
    output logic                          o_all_opaque,
    input  logic                          i_cfg_we,
    input  logic [bisc_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [bisc_pkg::CFG_BITS-1:0] i_cfg_data
);
    import bisc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bisc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bisc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_pixel_in   (i_pixel_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_last       (o_last),
        .o_all_opaque (o_all_opaque)
    );

endmodule

### sv/bisc_chk.sv
module bisc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_kind,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pixel_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_out))
        else $error("stalled result changed");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready && !i_kind |=> !o_out_valid)
        else $error("load item produced a result");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind |=> !o_in_ready)
        else $error("second item taken during compute");

endmodule

bind bilinear_image_scaler_unit bisc_chk u_chk (.*);
